// ===== sv/wpan_pkg.sv =====
package wpan_pkg;

	// store geometry
	localparam int STORE_DEPTH = 65536;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int WORD_W      = 16;

	// divider geometry: dividend is |sum| << 8
	localparam int FRAC_W  = 8;
	localparam int DVD_W   = WORD_W + FRAC_W;
	localparam int DCNT_W  = $clog2(DVD_W + 1);

	// command codes
	localparam logic [1:0] CMD_ACCUMULATE = 2'd0;
	localparam logic [1:0] CMD_NORMALIZE  = 2'd1;
	localparam logic [1:0] CMD_CLEAR      = 2'd2;

	typedef struct packed {
		logic [1:0]               command;
		logic [15:0]              pixel_address;
		logic signed [WORD_W-1:0] sample;
		logic [8:0]               weight;
	} item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] blended_value;
		logic                     covered;
	} result_t;

endpackage

// ===== sv/weighted_pixel_accumulate_normalize.sv =====
// Per-pixel weighted accumulate and normalize store. Each entry of a single
// synchronous memory holds a 16-bit blended sum and a 16-bit weight sum.
// After reset the block sweeps the whole memory to zero, one entry per cycle,
// and holds item_ready low meanwhile. Items are then taken one at a time:
// clear and command 3 are done at their accept; accumulate reads the memory,
// then adds and writes back; a normalize of an uncovered entry reads the
// memory, checks the flag and loads the output; and a covered normalize
// reads the memory, starts the divider, runs its 24 bit-serial quotient
// steps, captures the result and loads the output. A normalize result sits
// in an output register, so the next item is accepted while it waits for
// result_ready; a normalize that reaches its output load while the previous
// result is still unaccepted holds there until that result leaves. Command 3
// and addresses at or above STORE_DEPTH change nothing; a normalize of such
// an address returns zero, not covered.
module weighted_pixel_accumulate_normalize (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  wpan_pkg::item_t   item_data,
	output logic              result_valid,
	input  logic              result_ready,
	output wpan_pkg::result_t result_data
);
	import wpan_pkg::*;

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_ACC   = 6'b000100,
		S_NORM  = 6'b001000,
		S_DIV   = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t             state_q;
	logic [ADDR_W-1:0]  clr_q;
	logic               result_valid_q;
	result_t            result_q;
	result_t            res_q;

	// item held through its processing
	logic [1:0]         cmd_s1;
	logic [ADDR_W-1:0]  idx_s1;
	logic               ok_s1;
	logic [8:0]         wt_s1;
	logic [WORD_W-1:0]  inc_s1;
	logic [2*WORD_W-1:0] rdata_s1;

	logic [2*WORD_W-1:0] mem [STORE_DEPTH];

	logic                 accept;
	logic                 addr_ok;
	logic [ADDR_W-1:0]    item_idx;
	logic signed [25:0]   product;
	logic                 mem_we;
	logic [ADDR_W-1:0]    mem_wa;
	logic [2*WORD_W-1:0]  mem_wd;
	logic [WORD_W-1:0]    rd_sum;
	logic [WORD_W-1:0]    rd_wsum;
	logic                 covered;
	logic                 div_start;
	logic                 div_done;
	logic [WORD_W-1:0]    div_quo;
	logic                 out_free;

	assign item_ready   = (state_q == S_IDLE);
	assign accept       = item_valid && item_ready;
	assign addr_ok      = 32'(item_data.pixel_address) < 32'(STORE_DEPTH);
	assign item_idx     = ADDR_W'(item_data.pixel_address);
	assign product      = item_data.sample * $signed({1'b0, item_data.weight});

	assign rd_sum       = rdata_s1[2*WORD_W-1:WORD_W];
	assign rd_wsum      = rdata_s1[WORD_W-1:0];
	assign covered      = ok_s1 && !rd_wsum[WORD_W-1] && (rd_wsum != '0);
	assign div_start    = (state_q == S_NORM) && covered;
	assign out_free     = !result_valid_q || result_ready;

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

	// memory write port: clearing pass, clear command, accumulate write-back
	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_s1;
		mem_wd = '0;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
			end
			S_IDLE: begin
				mem_we = accept && addr_ok && (item_data.command == CMD_CLEAR);
				mem_wa = item_idx;
			end
			S_ACC: begin
				mem_we = ok_s1;
				mem_wd = {rd_sum + inc_s1, rd_wsum + WORD_W'(wt_s1)};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (accept) begin
			rdata_s1 <= mem[item_idx];
		end
	end

	// capture the transaction; floor of product >> 8 is its bits 23:8
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= item_data.command;
			idx_s1 <= item_idx;
			ok_s1  <= addr_ok;
			wt_s1  <= item_data.weight;
			inc_s1 <= product[WORD_W+FRAC_W-1:FRAC_W];
		end
	end

	// pending normalize result
	always_ff @(posedge clk) begin
		if (state_q == S_NORM) begin
			res_q <= '{blended_value: '0, covered: 1'b0};
		end else if ((state_q == S_DIV) && div_done) begin
			res_q <= '{blended_value: $signed(div_quo), covered: 1'b1};
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(STORE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (item_data.command == CMD_ACCUMULATE) begin
							state_q <= S_ACC;
						end else if (item_data.command == CMD_NORMALIZE) begin
							state_q <= S_NORM;
						end
					end
				end
				S_ACC: begin
					state_q <= S_IDLE;
				end
				S_NORM: begin
					state_q <= covered ? S_DIV : S_DONE;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			result_q <= res_q;
		end
	end

	// quotient of (sum << 8) by (weight sum + 1)
	wpan_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.numer    ($signed(rd_sum)),
		.denom    (rd_wsum + 1'b1),
		.done     (div_done),
		.quotient (div_quo)
	);

	// a new result only ever comes out of the completion state
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside completion state");

	// the divider is only started on a covered normalize
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (state_q == S_NORM) && (cmd_s1 == CMD_NORMALIZE))
		else $error("divider started outside normalize");

	// no store write while a normalize is in flight
	a_no_write_norm: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_CLEAR || state_q == S_IDLE || state_q == S_ACC))
		else $error("store written during normalize");

	// an accepted normalize always reads the store next
	a_norm_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (item_data.command == CMD_NORMALIZE) |=> state_q == S_NORM)
		else $error("normalize transaction lost");

	// divider finishes only while waited on
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider done out of sequence");

endmodule

// ===== sv/wpan_div.sv =====
module wpan_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [wpan_pkg::WORD_W-1:0] numer,
	input  logic [wpan_pkg::WORD_W-1:0]        denom,
	output logic                               done,
	output logic [wpan_pkg::WORD_W-1:0]        quotient
);
	import wpan_pkg::*;

	logic [DCNT_W-1:0] cnt_q;
	logic              done_q;
	logic              neg_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] den_q;

	logic [WORD_W:0]   numer_ext;
	logic [WORD_W:0]   numer_mag;
	logic [WORD_W:0]   rem_shift;
	logic [WORD_W+1:0] rem_diff;
	logic              borrow;

	// magnitude of the signed sum; 32768 still fits in the low word
	assign numer_ext = {numer[WORD_W-1], numer};
	assign numer_mag = numer[WORD_W-1] ? (~numer_ext + 1'b1) : numer_ext;

	// one restoring step: shift in the next dividend bit, try the subtract
	assign rem_shift = {rem_q, dvd_q[DVD_W-1]};
	assign rem_diff  = {1'b0, rem_shift} - {2'b00, den_q};
	assign borrow    = rem_diff[WORD_W+1];

	// control: step counter and completion flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= DCNT_W'(DVD_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: quotient bits shift in behind the dividend
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= numer[WORD_W-1];
			den_q <= denom;
			rem_q <= '0;
			dvd_q <= {numer_mag[WORD_W-1:0], {FRAC_W{1'b0}}};
		end else if (cnt_q != '0) begin
			rem_q <= borrow ? rem_shift[WORD_W-1:0] : rem_diff[WORD_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], ~borrow};
		end
	end

	// truncation toward zero: divide magnitudes, then restore the sign
	assign done     = done_q;
	assign quotient = neg_q ? (~dvd_q[WORD_W-1:0] + 1'b1) : dvd_q[WORD_W-1:0];

endmodule

// ===== verif/weighted_pixel_accumulate_normalize_tb.sv =====
`timescale 1ns / 1ps

module weighted_pixel_accumulate_normalize_tb;

	import wpan_pkg::*;

	// command 3 has no function in the block
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_ITEMS   = 500;

	// model of the per-pixel store and the queue of normalize results it predicts
	class blend_scoreboard;
		bit [15:0] sum_mem [];
		bit [15:0] weight_mem [];
		result_t   expected_blends [$];
		int        error_count;

		function new();
			sum_mem     = new[STORE_DEPTH];
			weight_mem  = new[STORE_DEPTH];
			error_count = 0;
		endfunction

		// update the store for one accepted transaction and queue any result
		function void apply_item(item_t it);
			logic signed [31:0] product;
			logic signed [15:0] wsum;
			logic signed [15:0] bsum;
			int                 quotient;
			result_t            res;
			case (it.command)
				CMD_ACCUMULATE: begin
					product = it.sample * $signed({1'b0, it.weight});
					// floor shift by 8, then keep the low 16 bits
					sum_mem[it.pixel_address]    += product[23:8];
					weight_mem[it.pixel_address] += {7'd0, it.weight};
				end
				CMD_NORMALIZE: begin
					wsum = weight_mem[it.pixel_address];
					bsum = sum_mem[it.pixel_address];
					if (wsum > 0) begin
						quotient          = (int'(bsum) * 256) / (int'(wsum) + 1);
						res.blended_value = quotient[15:0];
						res.covered       = 1'b1;
					end else begin
						res.blended_value = '0;
						res.covered       = 1'b0;
					end
					expected_blends.push_back(res);
				end
				CMD_CLEAR: begin
					sum_mem[it.pixel_address]    = '0;
					weight_mem[it.pixel_address] = '0;
				end
				default: ;
			endcase
		endfunction

		// compare one accepted result with the oldest prediction
		function void check_blend(result_t got);
			result_t exp_res;
			if (expected_blends.size() == 0) begin
				$error("result transaction with no pending normalize: blended_value %0d covered %0b",
					got.blended_value, got.covered);
				error_count++;
				return;
			end
			exp_res = expected_blends.pop_front();
			if (got.blended_value !== exp_res.blended_value) begin
				$error("blended_value: expected %0d, actual %0d",
					exp_res.blended_value, got.blended_value);
				error_count++;
			end
			if (got.covered !== exp_res.covered) begin
				$error("covered: expected %0b, actual %0b", exp_res.covered, got.covered);
				error_count++;
			end
		endfunction
	endclass

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item_data;
	logic    result_valid;
	logic    result_ready;
	result_t result_data;

	blend_scoreboard blend_sb;
	int              send_idle_pct;
	int              rx_stall_pct;
	int              cycle_count;
	bit [15:0]       hot_addr [2];

	weighted_pixel_accumulate_normalize i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item_data    (item_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver back-pressure
	initial result_ready = 1'b0;
	always @(negedge clk) begin
		result_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
	end

	// result checking
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			blend_sb.check_blend(result_data);
		end
	end

	function automatic item_t make_item(logic [1:0] cmd, logic [15:0] addr,
		logic signed [15:0] smp, logic [8:0] wgt);
		item_t it;
		it.command       = cmd;
		it.pixel_address = addr;
		it.sample        = smp;
		it.weight        = wgt;
		return it;
	endfunction

	function automatic logic signed [15:0] pick_sample();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'($urandom_range(0, 15)) - 16'sd8;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [8:0] pick_weight(bit heavy);
		int r;
		r = $urandom_range(0, 99);
		if (heavy && r < 50) return 9'($urandom_range(200, 511));
		if (r < 10) return 9'd256;
		if (r < 18) return 9'd0;
		if (r < 85) return 9'($urandom_range(0, 256));
		return 9'($urandom_range(257, 511));
	endfunction

	// drive one transaction, with random idle cycles ahead of it
	task automatic send_item(item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item_valid = 1'b1;
		item_data  = it;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		blend_sb.apply_item(it);
		@(negedge clk);
	endtask

	// hold the sender until every pending result has come back
	task automatic drain_results();
		item_valid = 1'b0;
		while (blend_sb.expected_blends.size() > 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// extremes, zero weight, uncovered reads, unused command and clear
	task automatic run_directed();
		send_item(make_item(CMD_NORMALIZE,  16'd0,     16'sd0,      9'd0));
		send_item(make_item(CMD_ACCUMULATE, 16'd0,     16'sh7fff,   9'd256));
		send_item(make_item(CMD_NORMALIZE,  16'd0,     16'sd0,      9'd0));
		send_item(make_item(CMD_ACCUMULATE, 16'd0,     16'sh8000,   9'd511));
		send_item(make_item(CMD_NORMALIZE,  16'd0,     16'sd0,      9'd0));
		send_item(make_item(CMD_ACCUMULATE, 16'hffff,  -16'sd1,     9'd1));
		send_item(make_item(CMD_NORMALIZE,  16'hffff,  16'sh7fff,   9'd511));
		send_item(make_item(CMD_ACCUMULATE, 16'hffff,  16'sd1,      9'd0));
		send_item(make_item(CMD_NORMALIZE,  16'hffff,  16'sd0,      9'd0));
		send_item(make_item(CMD_UNUSED,     16'hffff,  16'sh8000,   9'd511));
		send_item(make_item(CMD_NORMALIZE,  16'hffff,  16'sd0,      9'd0));
		send_item(make_item(CMD_ACCUMULATE, 16'h5555,  16'sh7fff,   9'd511));
		send_item(make_item(CMD_ACCUMULATE, 16'h5555,  16'sh8000,   9'd300));
		send_item(make_item(CMD_NORMALIZE,  16'h5555,  16'sd0,      9'd0));
		send_item(make_item(CMD_ACCUMULATE, 16'haaaa,  16'sd1,      9'd255));
		send_item(make_item(CMD_NORMALIZE,  16'haaaa,  16'sd0,      9'd0));
		send_item(make_item(CMD_CLEAR,      16'hffff,  16'sh7fff,   9'd511));
		send_item(make_item(CMD_NORMALIZE,  16'hffff,  16'sd0,      9'd0));
		send_item(make_item(CMD_CLEAR,      16'd0,     16'sd0,      9'd0));
		send_item(make_item(CMD_NORMALIZE,  16'd0,     16'sd0,      9'd0));
	endtask

	// random traffic: mostly accumulate runs closed by a normalize, plus noise
	task automatic run_phase(int n_items, int idle_pct, int stall_pct);
		int        sent;
		int        kind;
		int        run_len;
		bit        hot;
		bit [15:0] addr;
		send_idle_pct = idle_pct;
		rx_stall_pct  = stall_pct;
		sent          = 0;
		while (sent < n_items) begin
			kind = $urandom_range(0, 99);
			hot  = ($urandom_range(0, 99) < 60);
			addr = hot ? hot_addr[$urandom_range(0, 1)] : 16'($urandom);
			if (kind < 70) begin
				run_len = $urandom_range(1, 6);
				repeat (run_len) begin
					send_item(make_item(CMD_ACCUMULATE, addr, pick_sample(), pick_weight(hot)));
					sent++;
				end
				send_item(make_item(CMD_NORMALIZE, addr, pick_sample(), pick_weight(0)));
				sent++;
				if (!hot && $urandom_range(0, 9) == 0) begin
					send_item(make_item(CMD_CLEAR, addr, pick_sample(), pick_weight(0)));
					sent++;
				end
			end else if (kind < 85) begin
				send_item(make_item(CMD_NORMALIZE, addr, pick_sample(), pick_weight(0)));
				sent++;
			end else if (kind < 95) begin
				// clears of the heavily used entries stay rare so their weight sums wrap
				if (hot && $urandom_range(0, 9) != 0) addr = 16'($urandom);
				send_item(make_item(CMD_CLEAR, addr, pick_sample(), pick_weight(0)));
				sent++;
			end else begin
				send_item(make_item(CMD_UNUSED, addr, pick_sample(), pick_weight(0)));
			end
		end
		drain_results();
	endtask

	// main sequence
	initial begin
		blend_sb      = new();
		arst_n        = 1'b0;
		item_valid    = 1'b0;
		item_data     = '0;
		send_idle_pct = 0;
		rx_stall_pct  = 0;
		hot_addr[0]   = 16'($urandom);
		hot_addr[1]   = 16'($urandom);
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		run_directed();
		drain_results();
		run_phase(PHASE_ITEMS, 0, 0);
		run_phase(PHASE_ITEMS, 85, 0);
		run_phase(PHASE_ITEMS, 0, 85);
		run_phase(PHASE_ITEMS, 16, 16);

		if (blend_sb.error_count == 0 && blend_sb.expected_blends.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
